@@ rtl/cau_pkg.sv @@
`timescale 1ns / 1ps
package cau_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int OUT_BITS      = 32;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_NEG  = 3'd4;
  localparam logic [2:0] OP_CONJ = 3'd5;
  localparam logic [2:0] OP_CMP  = 3'd6;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  typedef struct packed {
    logic [OUT_BITS-1:0] re;
    logic [OUT_BITS-1:0] im;
    logic                eq;
    logic [1:0]          st;
    logic                is_mul;
    logic                is_div;
    logic                neg_re;
    logic                neg_im;
    logic                ov_re;
    logic                ov_im;
  } side_t;

endpackage

@@ rtl/cau_div.sv @@
`timescale 1ns / 1ps
module cau_div import cau_pkg::*; #(
  parameter int W  = WORD_BITS_DEF,
  parameter int XW = 3 * WORD_BITS_DEF + FRAC_BITS_DEF + 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  side_t         in_side,
  input  logic [XW-1:0] num_re,
  input  logic [XW-1:0] num_im,
  input  logic [XW-1:0] den,
  output logic          out_valid,
  output side_t         out_side,
  output logic [W-1:0]  q_re,
  output logic [W-1:0]  q_im
);

  logic          v  [1:W];
  side_t         sd [1:W];
  logic [XW-1:0] rr [1:W];
  logic [XW-1:0] ri [1:W];
  logic [XW-1:0] dd [1:W];
  logic [W-1:0]  qr [1:W];
  logic [W-1:0]  qi [1:W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic          sv;
    side_t         ss;
    logic [XW-1:0] sr, si, sdn, dsh;
    logic [W-1:0]  sqr, sqi;
    logic          ge_r, ge_i;

    if (k == 0) begin : g_first
      assign sv  = in_valid;
      assign ss  = in_side;
      assign sr  = num_re;
      assign si  = num_im;
      assign sdn = den;
      assign sqr = '0;
      assign sqi = '0;
    end else begin : g_next
      assign sv  = v[k];
      assign ss  = sd[k];
      assign sr  = rr[k];
      assign si  = ri[k];
      assign sdn = dd[k];
      assign sqr = qr[k];
      assign sqi = qi[k];
    end

    assign dsh  = sdn << (W - 1 - k);
    assign ge_r = (sr >= dsh);
    assign ge_i = (si >= dsh);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else begin
        v[k+1] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      sd[k+1] <= ss;
      dd[k+1] <= sdn;
      rr[k+1] <= ge_r ? (sr - dsh) : sr;
      ri[k+1] <= ge_i ? (si - dsh) : si;
      qr[k+1] <= sqr | (W'(ge_r) << (W - 1 - k));
      qi[k+1] <= sqi | (W'(ge_i) << (W - 1 - k));
    end
  end

  assign out_valid = v[W];
  assign out_side  = sd[W];
  assign q_re      = qr[W];
  assign q_im      = qi[W];

endmodule

@@ rtl/complex_arithmetic_unit_top.sv @@
// The done strobe follows a request through stages 1 to 5, the divider and the registered done output.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// Divide runs through a WORD_BITS-stage restoring divider, one quotient bit per stage.
// Reset (rst, synchronous) clears only the valid bits; results cannot be held off.
`timescale 1ns / 1ps
module complex_arithmetic_unit_top import cau_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 opcode,
  input  logic signed [OUT_BITS-1:0] a_re,
  input  logic signed [OUT_BITS-1:0] a_im,
  input  logic signed [OUT_BITS-1:0] b_re,
  input  logic signed [OUT_BITS-1:0] b_im,
  output logic                       done,
  output logic signed [OUT_BITS-1:0] res_re,
  output logic signed [OUT_BITS-1:0] res_im,
  output logic                       equal,
  output logic [1:0]                 status
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int DW = 2 * W + 1;
  localparam int XW = 3 * W + F + 1;

  function automatic logic [W:0] sat_wide(input logic signed [DW-1:0] x);
    logic signed [DW-1:0] hi;
    logic [W:0]           r;
    hi = x >>> (W - 1);
    if (hi == '0 || hi == '1) begin
      r = {1'b0, x[W-1:0]};
    end else if (x[DW-1]) begin
      r = {2'b11, {(W-1){1'b0}}};
    end else begin
      r = {2'b10, {(W-1){1'b1}}};
    end
    return r;
  endfunction

  assign busy = 1'b0;

  // stage 1: operands
  logic                v1;
  logic [2:0]          op1;
  logic signed [W-1:0] ar1, ai1, br1, bi1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start;
    end
  end

  always_ff @(posedge clk) begin
    op1 <= opcode;
    ar1 <= a_re[W-1:0];
    ai1 <= a_im[W-1:0];
    br1 <= b_re[W-1:0];
    bi1 <= b_im[W-1:0];
  end

  // stage 2: products and simple ops
  side_t    side2_next;
  logic [W:0] s_re, s_im;

  always_comb begin
    side2_next = '0;
    s_re = '0;
    s_im = '0;
    unique case (op1)
      OP_ADD: begin
        s_re = sat_wide(DW'(ar1) + DW'(br1));
        s_im = sat_wide(DW'(ai1) + DW'(bi1));
      end
      OP_SUB: begin
        s_re = sat_wide(DW'(ar1) - DW'(br1));
        s_im = sat_wide(DW'(ai1) - DW'(bi1));
      end
      OP_NEG: begin
        s_re = sat_wide(-DW'(ar1));
        s_im = sat_wide(-DW'(ai1));
      end
      OP_CONJ: begin
        s_re = sat_wide(DW'(ar1));
        s_im = sat_wide(-DW'(ai1));
      end
      OP_CMP:  side2_next.eq = (ar1 == br1) && (ai1 == bi1);
      OP_MUL:  side2_next.is_mul = 1'b1;
      OP_DIV: begin
        side2_next.is_div = 1'b1;
        if (br1 == '0 && bi1 == '0) begin
          side2_next.st = ST_DIV0;
        end
      end
      default: ;
    endcase
    side2_next.re = OUT_BITS'($signed(s_re[W-1:0]));
    side2_next.im = OUT_BITS'($signed(s_im[W-1:0]));
    if (s_re[W] || s_im[W]) begin
      side2_next.st = ST_SAT;
    end
  end

  logic                  v2;
  side_t                 side2;
  logic signed [2*W-1:0] prr, pii, pir, pri, sqr, sqi;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    side2 <= side2_next;
    prr   <= ar1 * br1;
    pii   <= ai1 * bi1;
    pir   <= ai1 * br1;
    pri   <= ar1 * bi1;
    sqr   <= br1 * br1;
    sqi   <= bi1 * bi1;
  end

  // stage 3: multiply finish, divide sums
  side_t           side3_next;
  logic [W:0]      m_re, m_im;
  logic signed [DW-1:0] mre_sum, mim_sum;

  always_comb begin
    mre_sum = (DW'(prr) - DW'(pii)) >>> F;
    mim_sum = (DW'(pir) + DW'(pri)) >>> F;
    m_re = sat_wide(mre_sum);
    m_im = sat_wide(mim_sum);
    side3_next = side2;
    if (side2.is_mul) begin
      side3_next.re = OUT_BITS'($signed(m_re[W-1:0]));
      side3_next.im = OUT_BITS'($signed(m_im[W-1:0]));
      side3_next.st = (m_re[W] || m_im[W]) ? ST_SAT : ST_OK;
    end
  end

  logic                 v3;
  side_t                side3;
  logic signed [DW-1:0] dre3, dim3;
  logic [2*W-1:0]       den3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    side3 <= side3_next;
    dre3  <= DW'(prr) + DW'(pii);
    dim3  <= DW'(pir) - DW'(pri);
    den3  <= sqr + sqi;
  end

  // stage 4: magnitudes and scaling
  logic [DW-1:0] mag_re, mag_im;
  assign mag_re = dre3[DW-1] ? DW'(-dre3) : DW'(dre3);
  assign mag_im = dim3[DW-1] ? DW'(-dim3) : DW'(dim3);

  side_t side4_next;

  always_comb begin
    side4_next        = side3;
    side4_next.neg_re = dre3[DW-1];
    side4_next.neg_im = dim3[DW-1];
  end

  logic          v4;
  side_t         side4;
  logic [XW-1:0] num_re4, num_im4, den4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    side4   <= side4_next;
    num_re4 <= XW'(mag_re) << F;
    num_im4 <= XW'(mag_im) << F;
    den4    <= XW'(den3);
  end

  // stage 5: quotient overflow check
  side_t side5_next;

  always_comb begin
    side5_next       = side4;
    side5_next.ov_re = num_re4 >= (den4 << W);
    side5_next.ov_im = num_im4 >= (den4 << W);
  end

  logic          v5;
  side_t         side5;
  logic [XW-1:0] num_re5, num_im5, den5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    side5   <= side5_next;
    num_re5 <= num_re4;
    num_im5 <= num_im4;
    den5    <= den4;
  end

  logic         vd;
  side_t        sided;
  logic [W-1:0] q_re, q_im;

  cau_div #(
    .W  (W),
    .XW (XW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .in_side   (side5),
    .num_re    (num_re5),
    .num_im    (num_im5),
    .den       (den5),
    .out_valid (vd),
    .out_side  (sided),
    .q_re      (q_re),
    .q_im      (q_im)
  );

  // final: sign, saturate, select
  logic         sat_re, sat_im;
  logic [W-1:0] val_re, val_im;
  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  always_comb begin
    if (sided.neg_re) begin
      sat_re = sided.ov_re || (q_re[W-1] && (q_re[W-2:0] != '0));
      val_re = sat_re ? MINV : -q_re;
    end else begin
      sat_re = sided.ov_re || q_re[W-1];
      val_re = sat_re ? MAXV : q_re;
    end
    if (sided.neg_im) begin
      sat_im = sided.ov_im || (q_im[W-2:0] != '0 && q_im[W-1]);
      val_im = sat_im ? MINV : -q_im;
    end else begin
      sat_im = sided.ov_im || q_im[W-1];
      val_im = sat_im ? MAXV : q_im;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd;
    end
  end

  always_ff @(posedge clk) begin
    equal <= sided.eq;
    if (sided.is_div && sided.st != ST_DIV0) begin
      res_re <= OUT_BITS'($signed(val_re));
      res_im <= OUT_BITS'($signed(val_im));
      status <= (sat_re || sat_im) ? ST_SAT : ST_OK;
    end else begin
      res_re <= sided.re;
      res_im <= sided.im;
      status <= sided.st;
    end
  end

endmodule

@@ verif/complex_arithmetic_unit_top_test.sv @@
`timescale 1ns / 1ps
module complex_arithmetic_unit_top_test;
  import cau_pkg::*;

  localparam logic [2:0] OP_NONE = 3'd7;
  localparam logic signed [31:0] QMAX = 32'sh7fffffff;
  localparam logic signed [31:0] QMIN = 32'sh80000000;
  localparam logic signed [31:0] ONE  = 32'sh00010000;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        eq;
    logic [1:0]  st;
  } cresult_t;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] ar, ai, br, bi;
    bit          fixed;
    cresult_t    res;
  } row_t;

  logic clk, rst, start, busy, done, equal;
  logic [2:0] opcode;
  logic signed [31:0] a_re, a_im, b_re, b_im, res_re, res_im;
  logic [1:0] status;

  cresult_t pending_q[$];
  bit failed;

  complex_arithmetic_unit_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .done(done),
    .res_re(res_re), .res_im(res_im), .equal(equal), .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("complex_arithmetic_unit_top_test: errors");
    $finish;
  end

  function automatic logic [31:0] clamp(input logic signed [127:0] v, inout bit sat);
    if (v < 128'(QMIN)) begin
      sat = 1'b1;
      return QMIN;
    end
    if (v > 128'(QMAX)) begin
      sat = 1'b1;
      return QMAX;
    end
    return v[31:0];
  endfunction

  function automatic cresult_t complex_op(input logic [2:0] op,
                                          input logic signed [31:0] ar32, ai32,
                                          input logic signed [31:0] br32, bi32);
    logic signed [127:0] ar, ai, br, bi, den, nr, ni;
    cresult_t r;
    bit sat;
    ar = ar32;
    ai = ai32;
    br = br32;
    bi = bi32;
    r = '0;
    sat = 1'b0;
    case (op)
      OP_ADD: begin
        r.re = clamp(ar + br, sat);
        r.im = clamp(ai + bi, sat);
      end
      OP_SUB: begin
        r.re = clamp(ar - br, sat);
        r.im = clamp(ai - bi, sat);
      end
      OP_MUL: begin
        r.re = clamp((ar * br - ai * bi) >>> 16, sat);
        r.im = clamp((br * ai + ar * bi) >>> 16, sat);
      end
      OP_DIV: begin
        if (br == 0 && bi == 0) begin
          r.st = ST_DIV0;
        end else begin
          den = br * br + bi * bi;
          nr = (ar * br + ai * bi) <<< 16;
          ni = (br * ai - ar * bi) <<< 16;
          r.re = clamp(nr / den, sat);
          r.im = clamp(ni / den, sat);
        end
      end
      OP_NEG: begin
        r.re = clamp(-ar, sat);
        r.im = clamp(-ai, sat);
      end
      OP_CONJ: begin
        r.re = clamp(ar, sat);
        r.im = clamp(-ai, sat);
      end
      OP_CMP: r.eq = (ar == br) && (ai == bi);
      default: ;
    endcase
    if (sat && r.st == ST_OK) r.st = ST_SAT;
    return r;
  endfunction

  always @(posedge clk) begin
    cresult_t e;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result re=%h im=%h", res_re, res_im);
        failed = 1'b1;
      end else begin
        e = pending_q.pop_front();
        if (res_re !== e.re) begin
          $error("res_re expected %h actual %h", e.re, res_re);
          failed = 1'b1;
        end
        if (res_im !== e.im) begin
          $error("res_im expected %h actual %h", e.im, res_im);
          failed = 1'b1;
        end
        if (equal !== e.eq) begin
          $error("equal expected %b actual %b", e.eq, equal);
          failed = 1'b1;
        end
        if (status !== e.st) begin
          $error("status expected %0d actual %0d", e.st, status);
          failed = 1'b1;
        end
      end
    end
  end

  // Call at a rising edge; return at the edge that takes the request.
  task automatic issue(input row_t r);
    start <= 1'b1;
    opcode <= r.op;
    a_re <= r.ar;
    a_im <= r.ai;
    b_re <= r.br;
    b_im <= r.bi;
    do @(negedge clk); while (busy);
    @(posedge clk);
    pending_q.push_back(r.fixed ? r.res : complex_op(r.op, r.ar, r.ai, r.br, r.bi));
  endtask

  task automatic idle(input bit quiet);
    int n, k;
    k = $urandom_range(0, 19);
    n = quiet || k < 12 ? 0 : (k < 18 ? $urandom_range(1, 3) : $urandom_range(8, 40));
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_val(input int cls);
    case (cls)
      0: return $urandom();
      1: return $urandom_range(0, 1) ? QMAX - $urandom_range(0, 3) : QMIN + $urandom_range(0, 3);
      2: return 32'($signed($urandom_range(0, 32'h3fffff)) - 32'sh200000);
      3: return $urandom_range(0, 1) ? 32'($urandom_range(0, 2)) : 32'hffffffff;
      default: return 32'($signed($urandom_range(0, 32'h7ffffff)) - 32'sh4000000);
    endcase
  endfunction

  row_t dir_tab[$];
  row_t r;

  initial begin
    failed = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    opcode = OP_ADD;
    a_re = '0;
    a_im = '0;
    b_re = '0;
    b_im = '0;
    dir_tab = '{
      '{OP_ADD,  ONE, ONE, ONE, ONE, 1'b1, '{32'h20000, 32'h20000, 1'b0, ST_OK}},
      '{OP_ADD,  QMAX, QMIN, QMAX, QMIN, 1'b1, '{QMAX, QMIN, 1'b0, ST_SAT}},
      '{OP_SUB,  QMIN, QMAX, ONE, -ONE, 1'b1, '{QMIN, QMAX, 1'b0, ST_SAT}},
      '{OP_SUB,  ONE, 0, ONE, 0, 1'b1, '{0, 0, 1'b0, ST_OK}},
      '{OP_MUL,  ONE, 0, ONE, 0, 1'b1, '{ONE, 0, 1'b0, ST_OK}},
      '{OP_MUL,  0, ONE, 0, ONE, 1'b1, '{-ONE, 0, 1'b0, ST_OK}},
      '{OP_MUL,  QMAX, QMAX, QMAX, QMIN, 1'b0, '0},
      '{OP_MUL,  QMIN, QMIN, QMIN, QMIN, 1'b0, '0},
      '{OP_MUL,  -1, 1, 1, -1, 1'b0, '0},
      '{OP_DIV,  ONE, ONE, 0, 0, 1'b1, '{0, 0, 1'b0, ST_DIV0}},
      '{OP_DIV,  QMIN, QMAX, 0, 0, 1'b1, '{0, 0, 1'b0, ST_DIV0}},
      '{OP_DIV,  ONE, 0, ONE, 0, 1'b1, '{ONE, 0, 1'b0, ST_OK}},
      '{OP_DIV,  QMAX, QMIN, 1, 0, 1'b0, '0},
      '{OP_DIV,  QMIN, QMIN, QMIN, QMIN, 1'b0, '0},
      '{OP_DIV,  -5, 7, 3, -1, 1'b0, '0},
      '{OP_DIV,  ONE, -ONE, 0, 1, 1'b0, '0},
      '{OP_NEG,  QMIN, ONE, 0, 0, 1'b1, '{QMAX, -ONE, 1'b0, ST_SAT}},
      '{OP_NEG,  QMAX, 0, 0, 0, 1'b1, '{QMIN + 1, 0, 1'b0, ST_OK}},
      '{OP_CONJ, QMIN, QMIN, 0, 0, 1'b1, '{QMIN, QMAX, 1'b0, ST_SAT}},
      '{OP_CONJ, ONE, ONE, QMAX, QMAX, 1'b1, '{ONE, -ONE, 1'b0, ST_OK}},
      '{OP_CMP,  QMIN, QMAX, QMIN, QMAX, 1'b1, '{0, 0, 1'b1, ST_OK}},
      '{OP_CMP,  QMIN, QMAX, QMIN, QMAX - 1, 1'b1, '{0, 0, 1'b0, ST_OK}},
      '{OP_CMP,  -1, 0, 0, 0, 1'b1, '{0, 0, 1'b0, ST_OK}},
      '{OP_NONE, QMAX, QMIN, ONE, ONE, 1'b1, '{0, 0, 1'b0, ST_OK}}
    };
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_tab[i]) begin
      issue(dir_tab[i]);
      idle(1'b0);
    end
    for (int i = 0; i < 700; i++) begin
      r.op = $urandom_range(0, 19) == 0 ? OP_NONE : 3'($urandom_range(0, 6));
      r.ar = pick_val($urandom_range(0, 4));
      r.ai = pick_val($urandom_range(0, 4));
      r.br = pick_val($urandom_range(0, 4));
      r.bi = pick_val($urandom_range(0, 4));
      if (r.op == OP_CMP && $urandom_range(0, 1)) begin
        r.br = r.ar;
        r.bi = $urandom_range(0, 1) ? r.ai : r.ai ^ (32'h1 << $urandom_range(0, 31));
      end
      if (r.op == OP_DIV && $urandom_range(0, 9) == 0) begin
        r.br = 0;
        r.bi = 0;
      end
      r.fixed = 1'b0;
      issue(r);
      idle((i / 64) % 3 == 1);
    end
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (!failed) $display("complex_arithmetic_unit_top_test: clean");
    else $display("complex_arithmetic_unit_top_test: errors");
    $finish;
  end

endmodule

@@ files.f @@
rtl/cau_pkg.sv
rtl/cau_div.sv
rtl/complex_arithmetic_unit_top.sv
verif/complex_arithmetic_unit_top_test.sv
